@@ design/u8cp_pkg.sv @@
`timescale 1ns / 1ps

package u8cp_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   localparam int CpWidth = 21;

   localparam logic [7:0] GLYPH_NONE = 8'hFE;

   localparam logic [CpWidth-1:0] LATIN_BASE = 21'h0000A0;
   localparam logic [CpWidth-1:0] LATIN_LAST = 21'h0000FF;
   localparam logic [CpWidth-1:0] BOX_BASE   = 21'h002500;
   localparam logic [CpWidth-1:0] BOX_LAST   = 21'h00259F;

   // U+00A0..U+00FF
   localparam logic [7:0] LATIN_GLYPHS [96] = '{
      8'hFF,8'hAD,8'h9B,8'h9C,8'hFE,8'h9D,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hA6,8'hAE,8'hAA,8'hFE,8'hFE,8'hFE,
      8'hF8,8'hF1,8'hFE,8'hFE,8'hFE,8'hE6,8'hFE,8'hFA,
      8'hFE,8'hFE,8'hA7,8'hAF,8'hAC,8'hAB,8'hFE,8'hA8,
      8'hFE,8'hFE,8'hFE,8'hFE,8'h8E,8'h8F,8'h92,8'h80,
      8'hFE,8'h90,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hA5,8'hFE,8'hFE,8'hFE,8'hFE,8'h99,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'h9A,8'hFE,8'hFE,8'hE1,
      8'h85,8'hA0,8'h83,8'hFE,8'h84,8'h86,8'h91,8'h87,
      8'h8A,8'h82,8'h88,8'h89,8'h8D,8'hA1,8'h8C,8'h8B,
      8'hFE,8'hA4,8'h95,8'hA2,8'h93,8'hFE,8'h94,8'hF6,
      8'hFE,8'h97,8'hA3,8'h96,8'h81,8'hFE,8'hFE,8'h98
   };

   // U+2500..U+259F: box drawing followed by block elements
   localparam logic [7:0] BOX_GLYPHS [160] = '{
      8'hC4,8'hFE,8'hB3,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hDA,8'hFE,8'hFE,8'hFE,
      8'hBF,8'hFE,8'hFE,8'hFE,8'hC0,8'hFE,8'hFE,8'hFE,
      8'hD9,8'hFE,8'hFE,8'hFE,8'hC3,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hB4,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hC2,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hC1,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hC5,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hCD,8'hBA,8'hD5,8'hD6,8'hC9,8'hB8,8'hB7,8'hBB,
      8'hD4,8'hD3,8'hC8,8'hBE,8'hBD,8'hBC,8'hC6,8'hC7,
      8'hCC,8'hB5,8'hB6,8'hB9,8'hD1,8'hD2,8'hCB,8'hCF,
      8'hD0,8'hCA,8'hD8,8'hD7,8'hCE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hDF,8'hFE,8'hFE,8'hFE,8'hDC,8'hFE,8'hFE,8'hFE,
      8'hDB,8'hFE,8'hFE,8'hFE,8'hDD,8'hFE,8'hFE,8'hFE,
      8'hDE,8'hB0,8'hB1,8'hB2,8'hFE,8'hFE,8'hFE,8'hFE,
      8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE
   };

endpackage

@@ design/utf8_to_cp437_decoder.sv @@
`timescale 1ns / 1ps

// UTF-8 to CP437 decoder.
//
// The req channel carries one byte of a UTF-8 stream per item; the rsp channel
// returns exactly one item per byte, in order. A result has status pending
// (more bytes needed), complete (code point and CP437 glyph valid) or error
// (bad lead byte or missing continuation; the byte is dropped and decoding
// restarts). Code point and glyph read zero unless the status is complete.
//
// The block has two register stages: an input register that holds the
// accepted byte, and a result register loaded after the decode, the sequence
// state update and the glyph table lookup. A result is shown on rsp once its
// byte has passed the input register and then been loaded into the result
// register. One byte is taken every cycle as long as the receiver keeps up.
//
// Reset clears both stages and the sequence state. When the receiver stalls,
// the result register holds, the input register fills, and req_ready drops
// only once both stages are occupied; no item is lost or repeated.
module utf8_to_cp437_decoder
   import u8cp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic [7:0]         rsp_glyph
);

   // Input stage.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Sequence state.
   logic [CpWidth-1:0] partial_ff, partial_in;
   logic [1:0]         bytes_left_ff, bytes_left_in;

   // Result stage.
   logic               out_valid_ff;
   status_type         status_ff, status_in;
   logic [CpWidth-1:0] code_point_ff, code_point_in;
   logic [7:0]         glyph_ff;

   logic               advance;
   logic [CpWidth-1:0] shifted;
   logic [7:0]         mapped_glyph;

   // The input stage moves into the result stage whenever the result slot is
   // empty or being emptied this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign shifted = {partial_ff[CpWidth-7:0], in_byte_ff[5:0]};

   always_comb begin
      partial_in    = partial_ff;
      bytes_left_in = bytes_left_ff;
      status_in     = ST_PENDING;
      code_point_in = '0;
      if (bytes_left_ff == 2'd0) begin
         if (!in_byte_ff[7]) begin
            status_in     = ST_COMPLETE;
            code_point_in = {{(CpWidth-8){1'b0}}, in_byte_ff};
         end else if (in_byte_ff[7:5] == 3'b110) begin
            partial_in    = {{(CpWidth-5){1'b0}}, in_byte_ff[4:0]};
            bytes_left_in = 2'd1;
         end else if (in_byte_ff[7:4] == 4'b1110) begin
            partial_in    = {{(CpWidth-4){1'b0}}, in_byte_ff[3:0]};
            bytes_left_in = 2'd2;
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            partial_in    = {{(CpWidth-3){1'b0}}, in_byte_ff[2:0]};
            bytes_left_in = 2'd3;
         end else begin
            // Stray continuation byte or an invalid lead byte.
            partial_in    = '0;
            status_in     = ST_ERROR;
         end
      end else if (in_byte_ff[7:6] != 2'b10) begin
         // Sequence cut short: drop the byte and start over.
         partial_in    = '0;
         bytes_left_in = 2'd0;
         status_in     = ST_ERROR;
      end else if (bytes_left_ff == 2'd1) begin
         partial_in    = '0;
         bytes_left_in = 2'd0;
         status_in     = ST_COMPLETE;
         code_point_in = shifted;
      end else begin
         partial_in    = shifted;
         bytes_left_in = bytes_left_ff - 2'd1;
      end
   end

   u8cp_glyph_map u_glyph_map (
      .code_point (code_point_in),
      .glyph      (mapped_glyph)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         partial_ff    <= '0;
         bytes_left_ff <= 2'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            partial_ff    <= partial_in;
            bytes_left_ff <= bytes_left_in;
         end else if (rsp_ready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         status_ff     <= status_in;
         code_point_ff <= code_point_in;
         glyph_ff      <= (status_in == ST_COMPLETE) ? mapped_glyph : 8'h00;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_glyph      = glyph_ff;

   // An error always leaves the sequence state back at its reset values.
   assert property (@(posedge clock) disable iff (reset)
      advance && (status_in == ST_ERROR) |=> (bytes_left_ff == 2'd0) && (partial_ff == '0))
      else $error("sequence state not cleared after error");

   // A held byte in the input stage must not change while the result stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input stage lost or changed a stalled item");

   // Results other than complete carry no code point and no glyph.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_COMPLETE) |-> (rsp_code_point == '0) && (rsp_glyph == 8'h00))
      else $error("non-complete result carries data");

   // ASCII passes through unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_COMPLETE) && (rsp_code_point < 21'h000080)
         |-> rsp_glyph == rsp_code_point[7:0])
      else $error("ASCII glyph differs from code point");

   // Status code 3 is never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_PENDING) || (rsp_status == ST_COMPLETE)
         || (rsp_status == ST_ERROR))
      else $error("undefined status on result");

endmodule

@@ design/u8cp_glyph_map.sv @@
`timescale 1ns / 1ps

// Maps a Unicode code point to its CP437 glyph.
module u8cp_glyph_map
   import u8cp_pkg::*;
(
   input  logic [CpWidth-1:0] code_point,
   output logic [7:0]         glyph
);

   logic [7:0] latin_offset;
   logic [7:0] box_offset;

   assign latin_offset = code_point[7:0] - LATIN_BASE[7:0];
   assign box_offset   = code_point[7:0];

   always_comb begin
      if (code_point < 21'h000080) begin
         glyph = code_point[7:0];
      end else if (code_point inside {[LATIN_BASE:LATIN_LAST]}) begin
         glyph = LATIN_GLYPHS[latin_offset[6:0]];
      end else if (code_point inside {[BOX_BASE:BOX_LAST]}) begin
         glyph = BOX_GLYPHS[box_offset];
      end else begin
         // Short list of symbols with fixed glyphs.
         case (code_point)
            21'h002022: glyph = 8'h07;
            21'h0025CF: glyph = 8'h07;
            21'h0025CB: glyph = 8'h09;
            21'h002190: glyph = 8'h1B;
            21'h002191: glyph = 8'h18;
            21'h002192: glyph = 8'h1A;
            21'h002193: glyph = 8'h19;
            21'h002194: glyph = 8'h1D;
            21'h002195: glyph = 8'h12;
            21'h0021B5: glyph = 8'h17;
            21'h00221E: glyph = 8'hEC;
            21'h002248: glyph = 8'hF7;
            21'h002264: glyph = 8'hF3;
            21'h002265: glyph = 8'hF2;
            default:    glyph = GLYPH_NONE;
         endcase
      end
   end

endmodule
